[hw/rtl/psma_pkg.sv]
// psma_pkg: types and codes shared by the per-sensor moving average alarm
// depends on nothing; used by every module of the block
package psma_pkg;

   typedef enum logic {
      OP_REGISTER = 1'b0,
      OP_SAMPLE   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_HOT      = 3'd1,
      STAT_COLD     = 3'd2,
      STAT_FILLING  = 3'd3,
      STAT_UNKNOWN  = 3'd4,
      STAT_FULL     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_UPDATE,
      S_DIV,
      S_FINISH,
      S_DONE
   } state_type;

   localparam logic CSR_MAX_TEMP = 1'b0;
   localparam logic CSR_MIN_TEMP = 1'b1;

   typedef struct packed {
      op_type             op;
      logic [15:0]        node_id;
      logic [15:0]        room_id;
      logic signed [15:0] sample_value;
      logic [31:0]        timestamp;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        room_out;
      logic signed [15:0] average;
      logic [31:0]        last_time;
   } rsp_type;

endpackage

[hw/rtl/psma_front.sv]
// psma_front: accepts input items, classifies them and queues them for the back end
// depends on psma_pkg
module psma_front import psma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [15:0]        req_node_id,
   input  logic [15:0]        req_room_id,
   input  logic signed [15:0] req_sample_value,
   input  logic [31:0]        req_timestamp,
   input  logic               q_pop,
   output logic               q_empty,
   output req_type            q_head
);

   req_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;
   req_type     item;

   assign req_full = (count_ff == 2'd2);
   assign q_empty  = (count_ff == 2'd0);
   assign q_head   = entry_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && !q_empty;

   always_comb begin
      item.op           = req_action ? OP_SAMPLE : OP_REGISTER;
      item.node_id      = req_node_id;
      item.room_id      = req_room_id;
      item.sample_value = req_sample_value;
      item.timestamp    = req_timestamp;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[hw/rtl/psma_rsp_q.sv]
// psma_rsp_q: two-entry result queue in front of the result ports
// depends on psma_pkg
module psma_rsp_q import psma_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type head
);

   rsp_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/psma_back.sv]
// psma_back: sensor table, sample window memory, running sums and reciprocal divide
// depends on psma_pkg; fed by psma_front, drains into psma_rsp_q
module psma_back import psma_pkg::*; #(
   parameter int MAX_SENSORS = 16,
   parameter int WINDOW      = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  req_type            q_head,
   output logic               q_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rsp_type            rsp_data,
   input  logic signed [15:0] max_temp,
   input  logic signed [15:0] min_temp
);

   localparam int IW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CW    = $clog2(MAX_SENSORS + 1);
   localparam int FW    = $clog2(WINDOW + 1);
   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DEPTH = MAX_SENSORS * WINDOW;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = 17 + $clog2(WINDOW);
   localparam int MW    = SW - 1;
   localparam int DS    = MW + $clog2(WINDOW);
   localparam int MCW   = MW + 2;
   localparam int PRW   = MW + MCW;
   // ceil(2^DS / WINDOW) gives an exact floor quotient for any magnitude below 2^MW
   localparam longint RECIP_L = ((longint'(1) << DS) + longint'(WINDOW) - longint'(1))
                                / longint'(WINDOW);
   localparam logic [MCW-1:0] RECIP = MCW'(RECIP_L);

   state_type state_ff, state_in;

   logic [15:0]          id_ff   [MAX_SENSORS];
   logic [15:0]          room_ff [MAX_SENSORS];
   logic [31:0]          time_ff [MAX_SENSORS];
   logic signed [15:0]   avg_ff  [MAX_SENSORS];
   logic [FW-1:0]        fill_ff [MAX_SENSORS];
   logic [PW-1:0]        ptr_ff  [MAX_SENSORS];
   logic signed [SW-1:0] sum_ff  [MAX_SENSORS];
   logic signed [15:0]   hist_mem [DEPTH];

   logic [CW-1:0]        count_ff;
   logic [IW-1:0]        idx_ff;
   req_type              item_ff;
   rsp_type              res_ff;
   logic signed [15:0]   rd_ff;
   logic [MW-1:0]        mag_ff;
   logic [PRW-1:0]       prod_ff;
   logic                 neg_ff;
   logic                 found_ff;

   logic                 tbl_full, last_idx, id_hit;
   logic [AW-1:0]        hist_addr;
   logic signed [15:0]   oldest;
   logic signed [SW-1:0] new_sum;
   logic [FW-1:0]        fill_next;
   logic signed [15:0]   avg_val;
   logic [15:0]          q16;

   assign tbl_full  = (count_ff == CW'(MAX_SENSORS));
   assign last_idx  = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign id_hit    = (id_ff[idx_ff] == item_ff.node_id);
   assign hist_addr = AW'(AW'(idx_ff) * AW'(WINDOW)) + AW'(ptr_ff[idx_ff]);
   // slot is unwritten until the window has filled once
   assign oldest    = (fill_ff[idx_ff] == FW'(WINDOW)) ? rd_ff : 16'sd0;
   assign new_sum   = sum_ff[idx_ff] + SW'(item_ff.sample_value) - SW'(oldest);
   assign fill_next = (fill_ff[idx_ff] < FW'(WINDOW)) ? fill_ff[idx_ff] + FW'(1)
                                                     : fill_ff[idx_ff];
   assign q16       = prod_ff[DS +: 16];
   assign avg_val   = neg_ff ? 16'(-q16) : q16;
   assign rsp_data  = res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               if (q_head.op == OP_REGISTER || count_ff == CW'(0)) state_in = S_DONE;
               else state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (id_hit) state_in = S_READ;
            else if (last_idx) state_in = S_DONE;
         end
         S_READ:   state_in = S_UPDATE;
         S_UPDATE: begin
            if (fill_next < FW'(WINDOW)) state_in = last_idx ? S_DONE : S_SCAN;
            else state_in = S_DIV;
         end
         S_DIV:    state_in = S_FINISH;
         S_FINISH: state_in = last_idx ? S_DONE : S_SCAN;
         S_DONE:   if (!rsp_full) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      q_pop    = (state_ff == S_IDLE) && !q_empty;
      rsp_push = (state_ff == S_DONE) && !rsp_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_head.op == OP_REGISTER && !tbl_full) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            item_ff  <= q_head;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            if (q_pop) begin
               if (q_head.op == OP_REGISTER) begin
                  if (tbl_full) begin
                     res_ff <= '{STAT_FULL, 16'd0, 16'sd0, 32'd0};
                  end else begin
                     id_ff[IW'(count_ff)]   <= q_head.node_id;
                     room_ff[IW'(count_ff)] <= q_head.room_id;
                     time_ff[IW'(count_ff)] <= 32'd0;
                     avg_ff[IW'(count_ff)]  <= 16'sd0;
                     fill_ff[IW'(count_ff)] <= '0;
                     ptr_ff[IW'(count_ff)]  <= '0;
                     sum_ff[IW'(count_ff)]  <= '0;
                     res_ff <= '{STAT_OK, q_head.room_id, 16'sd0, 32'd0};
                  end
               end else begin
                  res_ff <= '{STAT_UNKNOWN, 16'd0, 16'sd0, 32'd0};
               end
            end
         end
         S_SCAN: begin
            if (!id_hit && !last_idx) idx_ff <= idx_ff + IW'(1);
         end
         S_READ: rd_ff <= hist_mem[hist_addr];
         S_UPDATE: begin
            hist_mem[hist_addr] <= item_ff.sample_value;
            sum_ff[idx_ff]  <= new_sum;
            time_ff[idx_ff] <= item_ff.timestamp;
            fill_ff[idx_ff] <= fill_next;
            ptr_ff[idx_ff]  <= (ptr_ff[idx_ff] == PW'(WINDOW - 1)) ? '0
                                                                   : ptr_ff[idx_ff] + PW'(1);
            // only the earliest matching entry is reported
            if (!found_ff) begin
               res_ff <= '{STAT_FILLING, room_ff[idx_ff], avg_ff[idx_ff], item_ff.timestamp};
            end
            if (fill_next < FW'(WINDOW)) begin
               found_ff <= 1'b1;
               if (!last_idx) idx_ff <= idx_ff + IW'(1);
            end
            neg_ff <= new_sum[SW-1];
            mag_ff <= MW'(new_sum[SW-1] ? -new_sum : new_sum);
         end
         S_DIV: begin
            prod_ff <= PRW'(mag_ff) * PRW'(RECIP);
         end
         S_FINISH: begin
            avg_ff[idx_ff] <= avg_val;
            if (!found_ff) begin
               res_ff.average <= avg_val;
               if (avg_val > max_temp) res_ff.status <= STAT_HOT;
               else if (avg_val < min_temp) res_ff.status <= STAT_COLD;
               else res_ff.status <= STAT_OK;
            end
            found_ff <= 1'b1;
            if (!last_idx) idx_ff <= idx_ff + IW'(1);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/per_sensor_moving_average_alarm.sv]
// per_sensor_moving_average_alarm: top level with threshold registers
// depends on psma_pkg, psma_front, psma_back, psma_rsp_q
//
// Keeps up to MAX_SENSORS sensor entries, each with a WINDOW-deep sample
// window. The back end works on one item at a time. A register item, or a
// sample while the table is empty, goes from S_IDLE straight to S_DONE. A
// sample scans the table one entry per cycle; every entry with a matching
// id is updated in S_READ and S_UPDATE, followed by the reciprocal divide
// in S_DIV and S_FINISH once its window is full. The item is picked up in
// S_IDLE and the result is handed over from S_DONE, which waits while the
// result queue is full. Two-entry queues on the input and result sides let
// either side stall on its own.
module per_sensor_moving_average_alarm import psma_pkg::*; #(
   parameter int MAX_SENSORS = 16,
   parameter int WINDOW      = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [15:0]        req_node_id,
   input  logic [15:0]        req_room_id,
   input  logic signed [15:0] req_sample_value,
   input  logic [31:0]        req_timestamp,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_room_out,
   output logic signed [15:0] rsp_average,
   output logic [31:0]        rsp_last_time,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);

   logic signed [15:0] max_temp_ff, min_temp_ff;
   logic               q_empty, q_pop, res_full, res_push;
   req_type            q_head;
   rsp_type            res_data, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff <= 16'sd6400;
         min_temp_ff <= 16'sd4608;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_TEMP: max_temp_ff <= csr_data;
            CSR_MIN_TEMP: min_temp_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   psma_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_node_id      (req_node_id),
      .req_room_id      (req_room_id),
      .req_sample_value (req_sample_value),
      .req_timestamp    (req_timestamp),
      .q_pop            (q_pop),
      .q_empty          (q_empty),
      .q_head           (q_head)
   );

   psma_back #(
      .MAX_SENSORS (MAX_SENSORS),
      .WINDOW      (WINDOW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_full (res_full),
      .rsp_push (res_push),
      .rsp_data (res_data),
      .max_temp (max_temp_ff),
      .min_temp (min_temp_ff)
   );

   psma_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .head      (head)
   );

   assign rsp_status    = head.status;
   assign rsp_room_out  = head.room_out;
   assign rsp_average   = head.average;
   assign rsp_last_time = head.last_time;

endmodule
